### rtl/faq_pkg.sv
// Shared types and constants for the flame alarm qualifier.
// Holds the input and result word structs, register indexes and reset values.
`timescale 1ns / 1ps
`default_nettype none

package faq_pkg;

    localparam int SAMPLE_W = 12;

    typedef struct packed {
        logic [SAMPLE_W-1:0] ch1_sample0;
        logic [SAMPLE_W-1:0] ch1_sample1;
        logic [SAMPLE_W-1:0] ch1_sample2;
        logic [SAMPLE_W-1:0] ch1_sample3;
        logic [SAMPLE_W-1:0] ch1_sample4;
        logic [SAMPLE_W-1:0] ch2_sample0;
        logic [SAMPLE_W-1:0] ch2_sample1;
        logic [SAMPLE_W-1:0] ch2_sample2;
        logic [SAMPLE_W-1:0] ch2_sample3;
        logic [SAMPLE_W-1:0] ch2_sample4;
    } t_in_word;

    typedef struct packed {
        logic                flame_alarm;
        logic                ch1_fault;
        logic                ch2_fault;
        logic [SAMPLE_W-1:0] ch1_average;
        logic [SAMPLE_W-1:0] ch2_average;
    } t_out_word;

    // Per-channel qualifier controls for one tick
    typedef struct packed {
        logic hit;    // average at or above the limit on a healthy channel
        logic hold;   // masked: freeze count and flag
        logic clear;  // channel disabled: drop count and flag
    } t_chan_ctrl;

    // Configuration register indexes
    localparam logic [1:0] CFG_FLAME_LIMIT  = 2'd0;
    localparam logic [1:0] CFG_SHORT_LEVEL  = 2'd1;
    localparam logic [1:0] CFG_FLAME_MASK   = 2'd2;
    localparam logic [1:0] CFG_CH2_ENABLE   = 2'd3;

    localparam logic [SAMPLE_W-1:0] FLAME_LIMIT_RST = 12'd2048;
    localparam logic [SAMPLE_W-1:0] SHORT_LEVEL_RST = 12'd3850;

    // floor(x/5) for x < 20480 as (x * 52429) >> 18
    localparam int             SUM_W      = 15;
    localparam logic [15:0]    AVG_RECIP  = 16'd52429;
    localparam int             AVG_SHIFT  = 18;
    localparam int             PROD_W     = 31;

endpackage

`default_nettype wire

### rtl/faq_avg5.sv
// Floor average of five 12-bit samples: adder tree and reciprocal multiply.
// Depends on faq_pkg for widths and the reciprocal constant.
`timescale 1ns / 1ps
`default_nettype none

module faq_avg5 (
    input  wire logic [faq_pkg::SAMPLE_W-1:0] i_s0,
    input  wire logic [faq_pkg::SAMPLE_W-1:0] i_s1,
    input  wire logic [faq_pkg::SAMPLE_W-1:0] i_s2,
    input  wire logic [faq_pkg::SAMPLE_W-1:0] i_s3,
    input  wire logic [faq_pkg::SAMPLE_W-1:0] i_s4,
    output logic      [faq_pkg::SAMPLE_W-1:0] o_avg
);

    logic [faq_pkg::SUM_W-1:0]  w_sum;
    logic [faq_pkg::PROD_W-1:0] w_prod;

    assign w_sum = faq_pkg::SUM_W'(i_s0) + faq_pkg::SUM_W'(i_s1)
                 + faq_pkg::SUM_W'(i_s2) + faq_pkg::SUM_W'(i_s3)
                 + faq_pkg::SUM_W'(i_s4);

    assign w_prod = faq_pkg::PROD_W'(w_sum) * faq_pkg::PROD_W'(faq_pkg::AVG_RECIP);

    assign o_avg = w_prod[faq_pkg::AVG_SHIFT +: faq_pkg::SAMPLE_W];

endmodule

`default_nettype wire

### rtl/faq_chan.sv
// Flame persistence counter and flag for one sensor channel.
// Depends on faq_pkg for the control struct.
`timescale 1ns / 1ps
`default_nettype none

module faq_chan #(
    parameter int PERSIST_TICKS = 20
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_advance,
    input  wire faq_pkg::t_chan_ctrl i_ctrl,
    output logic                     o_flag_next
);

    localparam int CW = $clog2(PERSIST_TICKS + 1);
    localparam logic [CW:0] PERSIST_MAX = (CW+1)'(PERSIST_TICKS);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_flag;
    logic          n_flag;
    logic [CW:0]   w_inc;

    assign w_inc = {1'b0, r_count} + {{CW{1'b0}}, 1'b1};

    always_comb begin
        n_count = r_count;
        n_flag  = r_flag;
        if (i_ctrl.clear) begin
            n_count = '0;
            n_flag  = 1'b0;
        end else if (!i_ctrl.hold) begin
            if (i_ctrl.hit) begin
                if (w_inc >= PERSIST_MAX) begin
                    // saturate and raise the flag
                    n_count = PERSIST_MAX[CW-1:0];
                    n_flag  = 1'b1;
                end else begin
                    n_count = w_inc[CW-1:0];
                end
            end else begin
                n_count = '0;
                n_flag  = 1'b0;
            end
        end
    end

    assign o_flag_next = n_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_flag  <= 1'b0;
        end else if (i_advance) begin
            r_count <= n_count;
            r_flag  <= n_flag;
        end
    end

endmodule

`default_nettype wire

### rtl/flame_alarm_qualifier.sv
// Flame alarm qualifier: two-channel average, power-up short check, persistence.
// A word accepted into the input register moves on to the result register, where it shows
// as a valid result (input register, then result register); one word per cycle sustained
// while i_out_ready stays high, since both registers then advance every cycle.
// Reset (synchronous, active low) empties both stages, clears counters, flags,
// faults and the power-up tick count, and loads register reset values.
`timescale 1ns / 1ps
`default_nettype none

module flame_alarm_qualifier #(
    parameter int PERSIST_TICKS  = 20,
    parameter int POWERUP_WINDOW = 20
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire faq_pkg::t_in_word              i_in,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output faq_pkg::t_out_word                  o_out,
    input  wire logic                           i_cfg_we,
    input  wire logic [1:0]                     i_cfg_index,
    input  wire logic [faq_pkg::SAMPLE_W-1:0]   i_cfg_data
);

    localparam int PW = $clog2(POWERUP_WINDOW + 2);

    // configuration
    logic [faq_pkg::SAMPLE_W-1:0] r_flame_limit;
    logic [faq_pkg::SAMPLE_W-1:0] r_short_level;
    logic                         r_flame_mask;
    logic                         r_ch2_enable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flame_limit <= faq_pkg::FLAME_LIMIT_RST;
            r_short_level <= faq_pkg::SHORT_LEVEL_RST;
            r_flame_mask  <= 1'b0;
            r_ch2_enable  <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                faq_pkg::CFG_FLAME_LIMIT: r_flame_limit <= i_cfg_data;
                faq_pkg::CFG_SHORT_LEVEL: r_short_level <= i_cfg_data;
                faq_pkg::CFG_FLAME_MASK:  r_flame_mask  <= i_cfg_data[0];
                faq_pkg::CFG_CH2_ENABLE:  r_ch2_enable  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic               r_in_valid;
    faq_pkg::t_in_word  r_in;
    logic               r_out_valid;
    faq_pkg::t_out_word r_out;
    faq_pkg::t_out_word n_out;
    logic               w_adv_out;
    logic               w_step;

    assign w_adv_out  = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || w_adv_out;
    assign w_step     = r_in_valid && w_adv_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv_out) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in;
        end
        if (w_step) begin
            r_out <= n_out;
        end
    end

    // averages
    logic [faq_pkg::SAMPLE_W-1:0] w_avg1;
    logic [faq_pkg::SAMPLE_W-1:0] w_avg2;

    faq_avg5 u_avg1 (
        .i_s0  (r_in.ch1_sample0),
        .i_s1  (r_in.ch1_sample1),
        .i_s2  (r_in.ch1_sample2),
        .i_s3  (r_in.ch1_sample3),
        .i_s4  (r_in.ch1_sample4),
        .o_avg (w_avg1)
    );

    faq_avg5 u_avg2 (
        .i_s0  (r_in.ch2_sample0),
        .i_s1  (r_in.ch2_sample1),
        .i_s2  (r_in.ch2_sample2),
        .i_s3  (r_in.ch2_sample3),
        .i_s4  (r_in.ch2_sample4),
        .o_avg (w_avg2)
    );

    // power-up short check
    logic [PW-1:0] r_pu_ticks;
    logic          r_fault_one;
    logic          r_fault_two;
    logic          n_fault_one;
    logic          n_fault_two;
    logic          w_pu_open;

    assign w_pu_open   = r_pu_ticks <= PW'(POWERUP_WINDOW);
    assign n_fault_one = r_fault_one || (w_pu_open && (w_avg1 >= r_short_level));
    assign n_fault_two = r_fault_two
                      || (w_pu_open && r_ch2_enable && (w_avg2 >= r_short_level));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pu_ticks  <= '0;
            r_fault_one <= 1'b0;
            r_fault_two <= 1'b0;
        end else if (w_step) begin
            if (w_pu_open) begin
                r_pu_ticks <= r_pu_ticks + PW'(1);
            end
            r_fault_one <= n_fault_one;
            r_fault_two <= n_fault_two;
        end
    end

    // persistence per channel; a fault found this tick already blocks counting
    faq_pkg::t_chan_ctrl w_ctrl1;
    faq_pkg::t_chan_ctrl w_ctrl2;
    logic                w_flag1;
    logic                w_flag2;

    assign w_ctrl1.hit   = (w_avg1 >= r_flame_limit) && !n_fault_one;
    assign w_ctrl1.hold  = r_flame_mask;
    assign w_ctrl1.clear = 1'b0;
    assign w_ctrl2.hit   = (w_avg2 >= r_flame_limit) && !n_fault_two;
    assign w_ctrl2.hold  = r_flame_mask;
    assign w_ctrl2.clear = !r_ch2_enable;

    faq_chan #(.PERSIST_TICKS(PERSIST_TICKS)) u_chan1 (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (w_step),
        .i_ctrl      (w_ctrl1),
        .o_flag_next (w_flag1)
    );

    faq_chan #(.PERSIST_TICKS(PERSIST_TICKS)) u_chan2 (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (w_step),
        .i_ctrl      (w_ctrl2),
        .o_flag_next (w_flag2)
    );

    always_comb begin
        n_out.flame_alarm = !r_flame_mask && (w_flag1 || w_flag2);
        n_out.ch1_fault   = n_fault_one;
        n_out.ch2_fault   = n_fault_two;
        n_out.ch1_average = w_avg1;
        n_out.ch2_average = w_avg2;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    a_fault_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fault_one |=> r_fault_one)
        else $error("channel one fault cleared without reset");

    a_mask_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && r_flame_mask) |=> !r_out.flame_alarm)
        else $error("alarm raised while masked");

    a_pu_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pu_ticks <= PW'(POWERUP_WINDOW + 1))
        else $error("power-up tick count past window");
`endif

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking bench for flame_alarm_qualifier: a tick predictor with its own copy of the
// registers and channel state, power-up directed ticks, then random flame and quiet runs.
// Depends on faq_pkg and the flame_alarm_qualifier RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int PERSIST_TICKS  = 20;
    localparam int POWERUP_WINDOW = 20;
    localparam int SETTLE_CYCLES  = 4;
    localparam int END_CYCLES     = 8;
    localparam int CYCLE_LIMIT    = 600000;
    localparam int NUM_PHASES     = 16;
    localparam int PHASE_TICKS    = 92;

    typedef enum logic [1:0] {RUN_HOT, RUN_COLD, RUN_NOISE} t_run_kind;

    class flame_scoreboard;
        logic [faq_pkg::SAMPLE_W-1:0] flame_limit;
        logic [faq_pkg::SAMPLE_W-1:0] short_level;
        bit                           flame_mask;
        bit                           ch2_enable;
        int                           powerup_ticks;
        bit                           fault [2];
        int                           hold [2];
        bit                           flag [2];
        faq_pkg::t_out_word           expected_q [$];
        int                           errors;

        function new();
            flame_limit   = faq_pkg::FLAME_LIMIT_RST;
            short_level   = faq_pkg::SHORT_LEVEL_RST;
            flame_mask    = 1'b0;
            ch2_enable    = 1'b1;
            powerup_ticks = 0;
            errors        = 0;
            for (int c = 0; c < 2; c++) begin
                fault[c] = 1'b0;
                hold[c]  = 0;
                flag[c]  = 1'b0;
            end
        endfunction

        function void write_reg(logic [1:0] idx, logic [faq_pkg::SAMPLE_W-1:0] data);
            case (idx)
                faq_pkg::CFG_FLAME_LIMIT: flame_limit = data;
                faq_pkg::CFG_SHORT_LEVEL: short_level = data;
                faq_pkg::CFG_FLAME_MASK:  flame_mask  = data[0];
                faq_pkg::CFG_CH2_ENABLE:  ch2_enable  = data[0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Advance the channel state by one accepted tick and queue its result word
        function void note_tick(faq_pkg::t_in_word w);
            int                 avg [2];
            faq_pkg::t_out_word r;
            avg[0] = (int'(w.ch1_sample0) + int'(w.ch1_sample1) + int'(w.ch1_sample2)
                    + int'(w.ch1_sample3) + int'(w.ch1_sample4)) / 5;
            avg[1] = (int'(w.ch2_sample0) + int'(w.ch2_sample1) + int'(w.ch2_sample2)
                    + int'(w.ch2_sample3) + int'(w.ch2_sample4)) / 5;
            // short check comes first, so a channel found faulty counts no flame this tick
            if (powerup_ticks <= POWERUP_WINDOW) begin
                powerup_ticks++;
                if (avg[0] >= int'(short_level))
                    fault[0] = 1'b1;
                if (ch2_enable && avg[1] >= int'(short_level))
                    fault[1] = 1'b1;
            end
            if (!ch2_enable) begin
                hold[1] = 0;
                flag[1] = 1'b0;
            end
            r = '0;
            if (!flame_mask) begin
                for (int c = 0; c < 2; c++) begin
                    if (c == 0 || ch2_enable) begin
                        if (avg[c] >= int'(flame_limit) && !fault[c]) begin
                            hold[c] = (hold[c] + 1 >= PERSIST_TICKS) ? PERSIST_TICKS
                                                                     : hold[c] + 1;
                            if (hold[c] == PERSIST_TICKS)
                                flag[c] = 1'b1;
                        end else begin
                            hold[c] = 0;
                            flag[c] = 1'b0;
                        end
                    end
                end
                r.flame_alarm = flag[0] | flag[1];
            end
            r.ch1_fault   = fault[0];
            r.ch2_fault   = fault[1];
            r.ch1_average = 12'(avg[0]);
            r.ch2_average = 12'(avg[1]);
            expected_q.push_back(r);
        endfunction

        task report_mismatch(string what, int got, int want);
            if (errors < 40)
                $display("mismatch %s: got %0d, expected %0d", what, got, want);
            errors++;
        endtask

        task check_word(faq_pkg::t_out_word got);
            faq_pkg::t_out_word want;
            if (expected_q.size() == 0) begin
                report_mismatch("result word with no tick pending", int'(got.ch1_average), -1);
                return;
            end
            want = expected_q.pop_front();
            if (got.flame_alarm !== want.flame_alarm)
                report_mismatch("flame_alarm", int'(got.flame_alarm), int'(want.flame_alarm));
            if (got.ch1_fault !== want.ch1_fault)
                report_mismatch("ch1_fault", int'(got.ch1_fault), int'(want.ch1_fault));
            if (got.ch2_fault !== want.ch2_fault)
                report_mismatch("ch2_fault", int'(got.ch2_fault), int'(want.ch2_fault));
            if (got.ch1_average !== want.ch1_average)
                report_mismatch("ch1_average", int'(got.ch1_average), int'(want.ch1_average));
            if (got.ch2_average !== want.ch2_average)
                report_mismatch("ch2_average", int'(got.ch2_average), int'(want.ch2_average));
        endtask
    endclass

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_in_valid;
    logic                         o_in_ready;
    faq_pkg::t_in_word            i_in;
    logic                         o_out_valid;
    logic                         i_out_ready;
    faq_pkg::t_out_word           o_out;
    logic                         i_cfg_we;
    logic [1:0]                   i_cfg_index;
    logic [faq_pkg::SAMPLE_W-1:0] i_cfg_data;

    flame_scoreboard sb = new();

    int        in_idle_pct;
    int        out_idle_pct;
    int        cycles = 0;
    int        run_left [2] = '{0, 0};
    t_run_kind run_kind [2] = '{RUN_COLD, RUN_COLD};

    flame_alarm_qualifier #(
        .PERSIST_TICKS (PERSIST_TICKS),
        .POWERUP_WINDOW(POWERUP_WINDOW)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Note accepted ticks before checking, so a result in the same cycle still finds its tick
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                sb.note_tick(i_in);
            if (o_out_valid && i_out_ready)
                sb.check_word(o_out);
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99, 0) >= out_idle_pct);
    end

    function automatic faq_pkg::t_in_word flat_tick(logic [faq_pkg::SAMPLE_W-1:0] v1,
                                                    logic [faq_pkg::SAMPLE_W-1:0] v2);
        return faq_pkg::t_in_word'({{5{v1}}, {5{v2}}});
    endfunction

    function automatic logic [faq_pkg::SAMPLE_W-1:0] pick_level(t_run_kind kind, int lim);
        case (kind)
            RUN_HOT:  return 12'($urandom_range(4095, lim));
            RUN_COLD: return (lim == 0) ? 12'd0 : 12'($urandom_range(lim - 1, 0));
            default:  return 12'($urandom_range(4095, 0));
        endcase
    endfunction

    // Each channel walks through runs: long flame runs to reach the persistence count,
    // short quiet runs to break them, and some noise
    function automatic faq_pkg::t_in_word random_tick();
        logic [0:4][faq_pkg::SAMPLE_W-1:0] s [2];
        int lim;
        int r;
        int v;
        lim = int'(sb.flame_limit);
        for (int c = 0; c < 2; c++) begin
            if (run_left[c] == 0) begin
                r = $urandom_range(99, 0);
                if (r < 50) begin
                    run_kind[c] = RUN_HOT;
                    run_left[c] = $urandom_range(30, 1);
                end else if (r < 85) begin
                    run_kind[c] = RUN_COLD;
                    run_left[c] = $urandom_range(6, 1);
                end else begin
                    run_kind[c] = RUN_NOISE;
                    run_left[c] = $urandom_range(4, 1);
                end
            end
            run_left[c]--;
            for (int k = 0; k < 5; k++)
                s[c][k] = pick_level(run_kind[c], lim);
            // land the average right at the limit or one below it
            if ($urandom_range(9, 0) == 0) begin
                case (run_kind[c])
                    RUN_HOT:  v = lim + $urandom_range(4, 0);
                    RUN_COLD: v = lim - $urandom_range(5, 1);
                    default:  v = lim + $urandom_range(9, 0) - 5;
                endcase
                if (v < 0)
                    v = 0;
                if (v > 4095)
                    v = 4095;
                for (int k = 1; k < 5; k++)
                    s[c][k] = 12'(lim);
                s[c][0] = 12'(v);
            end
        end
        return faq_pkg::t_in_word'({s[0], s[1]});
    endfunction

    // Called at a falling edge; leaves valid high after the word is taken
    task automatic push_tick(input faq_pkg::t_in_word w);
        int gap;
        gap = 0;
        while ($urandom_range(99, 0) < in_idle_pct && gap < 20)
            gap++;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= w;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Drop valid and hold until every queued result has come out
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx,
                             input logic [faq_pkg::SAMPLE_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        sb.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    task automatic cfg_done();
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic mid_pause();
        settle();
        if ($urandom_range(1, 0) == 1)
            cfg_write(faq_pkg::CFG_FLAME_MASK, 12'(!sb.flame_mask));
        if ($urandom_range(3, 0) == 0)
            cfg_write(faq_pkg::CFG_CH2_ENABLE, 12'(!sb.ch2_enable));
        cfg_done();
    endtask

    task automatic set_phase(input int p);
        logic [faq_pkg::SAMPLE_W-1:0] lim;
        logic [faq_pkg::SAMPLE_W-1:0] short_lvl;
        case (p)
            0: lim = 12'd2048;
            1: lim = 12'd0;
            2: lim = 12'd4095;
            default: begin
                case ($urandom_range(4, 0))
                    0:       lim = 12'd1;
                    1:       lim = 12'd4094;
                    default: lim = 12'($urandom_range(4095, 0));
                endcase
            end
        endcase
        case ($urandom_range(2, 0))
            0:       short_lvl = 12'd0;
            1:       short_lvl = 12'd4095;
            default: short_lvl = 12'($urandom_range(4095, 0));
        endcase
        if (p == 3)
            short_lvl = 12'd0;
        if (p == 4)
            short_lvl = 12'd4095;
        settle();
        cfg_write(faq_pkg::CFG_FLAME_LIMIT, lim);
        cfg_write(faq_pkg::CFG_SHORT_LEVEL, short_lvl);
        cfg_write(faq_pkg::CFG_FLAME_MASK,
                  (p == 5 || $urandom_range(3, 0) == 0) ? 12'd1 : 12'd0);
        cfg_write(faq_pkg::CFG_CH2_ENABLE,
                  (p != 6 && $urandom_range(9, 0) >= 3) ? 12'd1 : 12'd0);
        cfg_done();
    endtask

    initial begin
        int faulty_ch;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in         = '0;
        i_out_ready  = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = faq_pkg::CFG_FLAME_LIMIT;
        i_cfg_data   = '0;
        in_idle_pct  = 29;
        out_idle_pct = 83;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Power-up window: 21 ticks with the short check live
        push_tick(flat_tick(12'd0, 12'd0));
        push_tick(faq_pkg::t_in_word'({12'd0, 12'd1, 12'd2, 12'd3, 12'd4,
                                       12'd4095, 12'd0, 12'd0, 12'd0, 12'd0}));
        push_tick(flat_tick(12'd3849, 12'd3849));
        // floor of the average lands one under the short level
        push_tick(faq_pkg::t_in_word'({12'd3850, 12'd3850, 12'd3850, 12'd3850, 12'd3849,
                                       {5{12'd2048}}}));
        push_tick(flat_tick(12'd2047, 12'd2047));
        settle();
        cfg_write(faq_pkg::CFG_CH2_ENABLE, 12'd0);
        cfg_done();
        // disabled channel skips the short check even at full scale
        push_tick(flat_tick(12'd100, 12'd4095));
        push_tick(flat_tick(12'd2500, 12'd4095));
        settle();
        cfg_write(faq_pkg::CFG_CH2_ENABLE, 12'd1);
        cfg_write(faq_pkg::CFG_SHORT_LEVEL, 12'd4000);
        cfg_write(faq_pkg::CFG_FLAME_MASK, 12'd1);
        cfg_done();
        push_tick(flat_tick(12'd3999, 12'd3999));
        settle();
        cfg_write(faq_pkg::CFG_FLAME_MASK, 12'd0);
        cfg_done();
        for (int k = 0; k < 12; k++)
            push_tick(flat_tick(12'($urandom_range(3999, 2048)),
                                12'($urandom_range(3999, 2048))));
        settle();
        cfg_write(faq_pkg::CFG_FLAME_MASK, 12'd1);
        cfg_done();
        // last window tick, masked: exact short level on the chosen channel (or none)
        faulty_ch = $urandom_range(2, 0);
        push_tick(flat_tick((faulty_ch == 0) ? 12'd4000 : 12'd3999,
                            (faulty_ch == 1) ? 12'd4000 : 12'd3999));
        settle();
        cfg_write(faq_pkg::CFG_FLAME_MASK, 12'd0);
        cfg_done();
        // window closed: full scale no longer marks a fault
        push_tick(flat_tick(12'd4095, 12'd4095));
        push_tick(faq_pkg::t_in_word'({12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4094,
                                       12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4094}));

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == 6) begin
                in_idle_pct  = 83;
                out_idle_pct = 29;
            end else if (p == 11) begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end
            set_phase(p);
            for (int n = 0; n < PHASE_TICKS; n++) begin
                if ($urandom_range(39, 0) == 0)
                    mid_pause();
                push_tick(random_tick());
            end
        end

        settle();
        repeat (END_CYCLES) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
